// ===== rtl/sdc_pkg.sv =====
package sdc_pkg;

  localparam int MANT_W     = 96;
  localparam int SCALE_W    = 5;
  localparam int CMD_W      = 3;
  localparam int CHUNK_W    = 24;
  localparam int NUM_CHUNKS = MANT_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int DIV_T_W    = CHUNK_W + 4;
  localparam int RECIP_W    = 29;
  localparam int RECIP_SH   = 32;
  localparam int PROD_W     = DIV_T_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_TEN = 29'd429496730;
  localparam logic [31:0]        OVF_TOP   = 32'h1999_9999;
  localparam logic [31:0]        OVF_MID   = 32'h9999_9999;
  localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);

  localparam logic [CMD_W-1:0] CMD_LT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EQ = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NE = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic div_last;
    logic capture;
  } dp_ctrl_t;

  typedef struct packed {
    logic left_zero;
    logic near_ovf;
  } dp_status_t;

endpackage

// ===== rtl/sdc_if.sv =====
interface sdc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic        a_sign;
  logic [4:0]  a_scale;
  logic [63:0] a_mant_lo;
  logic [31:0] a_mant_hi;
  logic        b_sign;
  logic [4:0]  b_scale;
  logic [63:0] b_mant_lo;
  logic [31:0] b_mant_hi;

  modport source (
    output valid, command, a_sign, a_scale, a_mant_lo, a_mant_hi,
           b_sign, b_scale, b_mant_lo, b_mant_hi,
    input  ready
  );
  modport sink (
    input  valid, command, a_sign, a_scale, a_mant_lo, a_mant_hi,
           b_sign, b_scale, b_mant_lo, b_mant_hi,
    output ready
  );
endinterface

interface sdc_out_if;
  logic valid;
  logic ready;
  logic relation_holds;

  modport source (output valid, relation_holds, input ready);
  modport sink (input valid, relation_holds, output ready);
endinterface

// ===== rtl/sdc_datapath.sv =====
module sdc_datapath (
  input  logic                  clk,
  input  logic [2:0]            command,
  input  logic                  a_sign,
  input  logic [4:0]            a_scale,
  input  logic [63:0]           a_mant_lo,
  input  logic [31:0]           a_mant_hi,
  input  logic                  b_sign,
  input  logic [4:0]            b_scale,
  input  logic [63:0]           b_mant_lo,
  input  logic [31:0]           b_mant_hi,
  input  sdc_pkg::dp_ctrl_t     ctrl,
  output sdc_pkg::dp_status_t   status,
  output logic                  relation_holds
);
  import sdc_pkg::*;

  logic [CMD_W-1:0]   cmd_r;
  logic               sa_r;
  logic               sb_r;
  logic               zero_r;
  logic               lo_is_a_r;
  logic [MANT_W-1:0]  lo_r;
  logic [MANT_W-1:0]  hi_r;
  logic [SCALE_W-1:0] left_r;
  logic [3:0]         rem_r;
  logic               res_r;

  logic [MANT_W-1:0]  a_m;
  logic [MANT_W-1:0]  b_m;
  logic               a_lower;
  logic [SCALE_W-1:0] diff;
  logic               skip;
  logic [MANT_W-1:0]  mul10;
  logic [DIV_T_W-1:0] div_t;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quot;
  logic [DIV_T_W-1:0] rem_full;
  logic [MANT_W-1:0]  a_mag;
  logic [MANT_W-1:0]  b_mag;
  logic               mag_lt;
  logic               mag_gt;
  logic               ord_lt;
  logic               ord_gt;
  logic               res;

  assign a_m     = {a_mant_hi, a_mant_lo};
  assign b_m     = {b_mant_hi, b_mant_lo};
  assign a_lower = a_scale < b_scale;
  assign diff    = a_lower ? (b_scale - a_scale) : (a_scale - b_scale);
  assign skip    = ((a_m == '0) && (b_m == '0)) || (a_sign != b_sign);

  assign mul10 = {lo_r[MANT_W-4:0], 3'b000} + {lo_r[MANT_W-2:0], 1'b0};

  // Long division by ten, one chunk per cycle from the top, via a reciprocal multiply.
  assign div_t    = {rem_r, hi_r[MANT_W-1 -: CHUNK_W]};
  assign prod     = PROD_W'(div_t) * PROD_W'(RECIP_TEN);
  assign quot     = prod[RECIP_SH +: CHUNK_W];
  assign rem_full = div_t - (DIV_T_W'({quot, 3'b000}) + DIV_T_W'({quot, 1'b0}));

  assign status.left_zero = (left_r == '0);
  assign status.near_ovf  = (lo_r[95:64] > OVF_TOP) ||
                            ((lo_r[95:64] == OVF_TOP) && (lo_r[63:32] > OVF_MID));

  assign a_mag  = lo_is_a_r ? lo_r : hi_r;
  assign b_mag  = lo_is_a_r ? hi_r : lo_r;
  assign mag_lt = a_mag < b_mag;
  assign mag_gt = a_mag > b_mag;

  always_comb begin
    if (zero_r) begin
      ord_lt = 1'b0;
      ord_gt = 1'b0;
    end else if (sa_r != sb_r) begin
      ord_lt = sa_r;
      ord_gt = ~sa_r;
    end else if (sa_r) begin
      ord_lt = mag_gt;
      ord_gt = mag_lt;
    end else begin
      ord_lt = mag_lt;
      ord_gt = mag_gt;
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_LT:  res = ord_lt;
      CMD_LE:  res = ~ord_gt;
      CMD_GT:  res = ord_gt;
      CMD_GE:  res = ~ord_lt;
      CMD_EQ:  res = ~ord_lt & ~ord_gt;
      CMD_NE:  res = ord_lt | ord_gt;
      default: res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r     <= command;
      sa_r      <= a_sign;
      sb_r      <= b_sign;
      zero_r    <= (a_m == '0) && (b_m == '0);
      lo_is_a_r <= a_lower;
      lo_r      <= a_lower ? a_m : b_m;
      hi_r      <= a_lower ? b_m : a_m;
      left_r    <= skip ? '0 : diff;
      rem_r     <= '0;
    end else if (ctrl.mul) begin
      lo_r   <= mul10;
      left_r <= left_r - 1'b1;
    end else if (ctrl.div) begin
      hi_r <= {hi_r[MANT_W-CHUNK_W-1:0], quot};
      if (ctrl.div_last) begin
        rem_r  <= '0;
        left_r <= left_r - 1'b1;
      end else begin
        rem_r <= rem_full[3:0];
      end
    end
    if (ctrl.capture) begin
      res_r <= res;
    end
  end

  assign relation_holds = res_r;

endmodule

// ===== rtl/sdc_ctrl.sv =====
module sdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sdc_pkg::dp_status_t status,
  output sdc_pkg::dp_ctrl_t   ctrl
);
  import sdc_pkg::*;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [CHUNK_IDX_W-1:0] chunk_r;
  logic [CHUNK_IDX_W-1:0] chunk_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   slot_free;

  assign slot_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (status.left_zero) begin
          if (slot_free) state_nxt = ST_IDLE;
        end else if (status.near_ovf) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (chunk_r == LAST_CHUNK) state_nxt = ST_ALIGN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_ALIGN: begin
        ctrl.capture = status.left_zero & slot_free;
        ctrl.mul     = ~status.left_zero & ~status.near_ovf;
      end
      ST_DIV: begin
        ctrl.div      = 1'b1;
        ctrl.div_last = (chunk_r == LAST_CHUNK);
      end
      default: ctrl = '0;
    endcase
  end

  always_comb begin
    chunk_nxt = chunk_r;
    if (ctrl.div) begin
      chunk_nxt = ctrl.div_last ? '0 : chunk_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (ctrl.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/scaled_decimal_compare_core.sv =====
// Compares two scaled decimals (sign, scale, 96-bit mantissa) under one of six relations and
// returns a single bit per item. One item is in work at a time: after the transfer in, each
// unit of scale difference (at most 31) is worked off either by multiplying the smaller-scale
// mantissa by ten or, once it nears overflow, by dividing the other mantissa by ten, 24 bits
// per cycle through one reciprocal multiplier. A final compare then sets the result.
// Operands that are both zero or differ in sign skip alignment. The result sits in an output
// register, so the next item is taken while an earlier result waits for its transfer.
module scaled_decimal_compare_core (
  input logic       clk,
  input logic       rst_n,
  sdc_in_if.sink    in_ch,
  sdc_out_if.source out_ch
);
  import sdc_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  sdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  sdc_datapath u_dp (
    .clk            (clk),
    .command        (in_ch.command),
    .a_sign         (in_ch.a_sign),
    .a_scale        (in_ch.a_scale),
    .a_mant_lo      (in_ch.a_mant_lo),
    .a_mant_hi      (in_ch.a_mant_hi),
    .b_sign         (in_ch.b_sign),
    .b_scale        (in_ch.b_scale),
    .b_mant_lo      (in_ch.b_mant_lo),
    .b_mant_hi      (in_ch.b_mant_hi),
    .ctrl           (ctrl),
    .status         (status),
    .relation_holds (out_ch.relation_holds)
  );

endmodule

// ===== rtl/sdc_checker.sv =====
module sdc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_relation_holds
);

  logic [1:0] pending_r;
  logic [1:0] pending_nxt;

  always_comb begin
    pending_nxt = pending_r + 2'(in_valid & in_ready) - 2'(out_valid & out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result dropped before its transfer.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_relation_holds))
    else $error("Result changed while stalled.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("Result offered with no item outstanding.");

  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 2'd2 |-> !in_ready)
    else $error("Input taken while an item is in work and a result waits.");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("More than two items outstanding.");

endmodule

bind scaled_decimal_compare_core sdc_checker u_sdc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_relation_holds (out_ch.relation_holds)
);

// ===== verif/sdc_cmp_tb_pkg.sv =====
`timescale 1ns / 1ps

package sdc_cmp_tb_pkg;

  import sdc_pkg::*;

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic               a_sign;
    logic [SCALE_W-1:0] a_scale;
    logic [63:0]        a_mant_lo;
    logic [31:0]        a_mant_hi;
    logic               b_sign;
    logic [SCALE_W-1:0] b_scale;
    logic [63:0]        b_mant_lo;
    logic [31:0]        b_mant_hi;
  } cmp_item_t;

  function automatic bit predict_relation(cmp_item_t it);
    logic [MANT_W-1:0] ma;
    logic [MANT_W-1:0] mb;
    logic [MANT_W-1:0] lo_m;
    logic [MANT_W-1:0] hi_m;
    bit                swap;
    bit                dividing;
    int unsigned       diff;
    int                ord;
    int                c;
    ma = {it.a_mant_hi, it.a_mant_lo};
    mb = {it.b_mant_hi, it.b_mant_lo};
    if (ma == '0 && mb == '0) begin
      ord = 0;
    end else if (it.a_sign != it.b_sign) begin
      ord = it.a_sign ? -1 : 1;
    end else begin
      swap = it.a_scale > it.b_scale;
      lo_m = swap ? mb : ma;
      hi_m = swap ? ma : mb;
      diff = swap ? it.a_scale - it.b_scale : it.b_scale - it.a_scale;
      dividing = 1'b0;
      for (int k = 0; k < diff; k++) begin
        // The low word is deliberately left out of the overflow test.
        if (!dividing && (lo_m[95:64] > OVF_TOP ||
                          (lo_m[95:64] == OVF_TOP && lo_m[63:32] > OVF_MID))) begin
          dividing = 1'b1;
        end
        if (dividing) begin
          hi_m = hi_m / 96'd10;
        end else begin
          lo_m = lo_m * 96'd10;
        end
      end
      ma = swap ? hi_m : lo_m;
      mb = swap ? lo_m : hi_m;
      c = (ma < mb) ? -1 : ((ma > mb) ? 1 : 0);
      ord = it.a_sign ? -c : c;
    end
    case (it.command)
      CMD_LT: return ord < 0;
      CMD_LE: return ord <= 0;
      CMD_GT: return ord > 0;
      CMD_GE: return ord >= 0;
      CMD_EQ: return ord == 0;
      CMD_NE: return ord != 0;
      default: return 1'b0;
    endcase
  endfunction

  class relation_scoreboard;
    bit expected_holds[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_transfer(cmp_item_t it);
      expected_holds.push_back(predict_relation(it));
    endfunction

    function void check_transfer(logic actual);
      bit want;
      if (expected_holds.size() == 0) begin
        mismatches++;
        $display("%0t: relation_holds %0b arrived with no transfer pending, expected none",
                 $time, actual);
      end else begin
        want = expected_holds.pop_front();
        if (actual !== want) begin
          mismatches++;
          $display("%0t: relation_holds mismatch, expected %0b, actual %0b",
                   $time, want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_holds.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_scaled_decimal_compare_core.sv =====
`timescale 1ns / 1ps

module tb_scaled_decimal_compare_core;

  import sdc_pkg::*;
  import sdc_cmp_tb_pkg::*;

  localparam int NUM_RANDOM   = 900;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int   hold_left;
  int   quiet_cycles;

  relation_scoreboard sb;
  cmp_item_t          seen;

  sdc_in_if  in_ch();
  sdc_out_if out_ch();

  scaled_decimal_compare_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic cmp_item_t make_item(logic [CMD_W-1:0] cmd,
                                          logic as, logic [SCALE_W-1:0] ks,
                                          logic [MANT_W-1:0] ma,
                                          logic bs, logic [SCALE_W-1:0] kb,
                                          logic [MANT_W-1:0] mb);
    cmp_item_t it;
    it.command   = cmd;
    it.a_sign    = as;
    it.a_scale   = ks;
    it.a_mant_hi = ma[95:64];
    it.a_mant_lo = ma[63:0];
    it.b_sign    = bs;
    it.b_scale   = kb;
    it.b_mant_hi = mb[95:64];
    it.b_mant_lo = mb[63:0];
    return it;
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    if ($urandom_range(15) == 0) begin
      return SCALE_W'($urandom_range(31, 29));
    end
    return SCALE_W'($urandom_range(28));
  endfunction

  function automatic logic [MANT_W-1:0] pick_mant();
    int unsigned       kind;
    logic [31:0]       mid;
    logic [MANT_W-1:0] m;
    kind = $urandom_range(99);
    m = {$urandom, $urandom, $urandom};
    if (kind < 5) begin
      m = '0;
    end else if (kind < 25) begin
      m = MANT_W'($urandom_range(1000));
    end else if (kind < 40) begin
      mid = OVF_MID + 32'($urandom_range(4)) - 32'd2;
      m = {OVF_TOP - 32'($urandom_range(1)), mid, 32'($urandom)};
    end else if (kind < 70) begin
      m = m >> $urandom_range(95);
    end
    return m;
  endfunction

  function automatic logic [MANT_W-1:0] scale_up(logic [MANT_W-1:0] m, int unsigned n);
    for (int k = 0; k < n; k++) begin
      m = m * 96'd10;
    end
    return m;
  endfunction

  function automatic cmp_item_t random_item();
    logic [CMD_W-1:0]   cmd;
    logic               as;
    logic               bs;
    logic [SCALE_W-1:0] ks;
    logic [SCALE_W-1:0] kb;
    logic [MANT_W-1:0]  ma;
    logic [MANT_W-1:0]  mb;
    int unsigned        kind;
    kind = $urandom_range(99);
    cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(7, 6)) : CMD_W'($urandom_range(5));
    as = 1'($urandom);
    bs = ($urandom_range(4) == 0) ? 1'($urandom) : as;
    ks = pick_scale();
    kb = pick_scale();
    ma = pick_mant();
    mb = pick_mant();
    if (kind < 3) begin
      ma = '0;
      mb = '0;
    end else if (kind < 30) begin
      // Same value at two scales, nudged by at most one unit.
      ma = ma >> $urandom_range(95, 40);
      if (kb >= ks) begin
        mb = scale_up(ma, kb - ks) + MANT_W'($urandom_range(2)) - 96'd1;
      end else begin
        mb = ma;
        ma = scale_up(mb, ks - kb) + MANT_W'($urandom_range(2)) - 96'd1;
      end
    end
    return make_item(cmd, as, ks, ma, bs, kb, mb);
  endfunction

  task automatic send_item(input cmp_item_t it);
    while (!calm && $urandom_range(99) < 19) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.command   = it.command;
    in_ch.a_sign    = it.a_sign;
    in_ch.a_scale   = it.a_scale;
    in_ch.a_mant_lo = it.a_mant_lo;
    in_ch.a_mant_hi = it.a_mant_hi;
    in_ch.b_sign    = it.b_sign;
    in_ch.b_scale   = it.b_scale;
    in_ch.b_mant_lo = it.b_mant_lo;
    in_ch.b_mant_hi = it.b_mant_hi;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = calm || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.command   = in_ch.command;
      seen.a_sign    = in_ch.a_sign;
      seen.a_scale   = in_ch.a_scale;
      seen.a_mant_lo = in_ch.a_mant_lo;
      seen.a_mant_hi = in_ch.a_mant_hi;
      seen.b_sign    = in_ch.b_sign;
      seen.b_scale   = in_ch.b_scale;
      seen.b_mant_lo = in_ch.b_mant_lo;
      seen.b_mant_hi = in_ch.b_mant_hi;
      sb.note_transfer(seen);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_transfer(out_ch.relation_holds);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("scaled_decimal_compare_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [MANT_W-1:0] all_ones;
    logic [MANT_W-1:0] edge_fire;
    logic [MANT_W-1:0] edge_wrap;
    sb = new();
    all_ones  = '1;
    edge_fire = {OVF_TOP, OVF_MID + 32'd1, 32'd0};
    edge_wrap = {OVF_TOP, OVF_MID, 32'hFFFF_FFFF};
    quiet_cycles    = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = '0;
    in_ch.a_sign    = 1'b0;
    in_ch.a_scale   = '0;
    in_ch.a_mant_lo = '0;
    in_ch.a_mant_hi = '0;
    in_ch.b_sign    = 1'b0;
    in_ch.b_scale   = '0;
    in_ch.b_mant_lo = '0;
    in_ch.b_mant_hi = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Two zeros of opposite sign and scale under every command, unused ones included.
    for (int c = 0; c < 8; c++) begin
      send_item(make_item(CMD_W'(c), 1'b1, 5'd28, '0, 1'b0, 5'd3, '0));
    end
    send_item(make_item(CMD_EQ, 1'b0, 5'd0, 96'd5, 1'b0, 5'd1, 96'd50));
    send_item(make_item(CMD_LT, 1'b1, 5'd0, 96'd1, 1'b0, 5'd0, 96'd1));
    send_item(make_item(CMD_GE, 1'b1, 5'd0, all_ones, 1'b1, 5'd28, all_ones));
    send_item(make_item(CMD_GT, 1'b0, 5'd31, all_ones, 1'b0, 5'd0, 96'd1));
    send_item(make_item(CMD_LE, 1'b0, 5'd0, edge_fire, 1'b0, 5'd3, edge_fire));
    send_item(make_item(CMD_NE, 1'b0, 5'd0, edge_wrap, 1'b0, 5'd1, all_ones));
    send_item(make_item(CMD_GT, 1'b0, 5'd0, edge_wrap, 1'b0, 5'd1, 96'd5));
    send_item(make_item(CMD_EQ, 1'b1, 5'd28, '0, 1'b0, 5'd0, 96'd1));
    send_item(make_item(CMD_LT, 1'b0, 5'd0, '0, 1'b1, 5'd31, 96'd1));
    send_item(make_item(CMD_NE, 1'b0, 5'd7, all_ones, 1'b0, 5'd7, all_ones));
    send_item(make_item(CMD_GT, 1'b0, 5'd0, {OVF_TOP, OVF_MID, 32'd0}, 1'b0, 5'd2,
                        {OVF_TOP, OVF_MID, 32'd0}));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) begin
        hold_req = 1'b1;
      end
      send_item(random_item());
    end
    in_ch.valid = 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("scaled_decimal_compare_core regression: pass");
    end else begin
      $display("scaled_decimal_compare_core regression: fail");
    end
    $finish;
  end

endmodule
